/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* rtl/core/cfwah_pkg.sv */
// ----------------------------------------------------------------------------
// cfwah_pkg
// Constants, lookup tables and config codes of the complex feedback wah.
// ----------------------------------------------------------------------------
package cfwah_pkg;

    localparam int MAX_DELAY_DEF = 128;
    localparam int BLOCK_LEN     = 128;
    localparam int BLK_SHIFT     = $clog2(BLOCK_LEN);
    localparam int POS_W         = $clog2(BLOCK_LEN + 1);
    localparam int SINE_N        = 256;
    localparam int SINE_W        = $clog2(SINE_N);

    // ceil(2^30 / 127): exact floor division by 127 for values below 2^23
    localparam logic signed [32:0] RECIP_127 = 33'sd8454661;

    typedef enum logic [2:0] {
        CFG_DEPTH    = 3'd0,
        CFG_FEEDBACK = 3'd1,
        CFG_LENGTH   = 3'd2,
        CFG_PHASE    = 3'd3,
        CFG_CROSS    = 3'd4,
        CFG_PAN_L    = 3'd5,
        CFG_PAN_R    = 3'd6
    } t_cfg_idx;

    typedef logic signed [15:0] t_trig_tab [SINE_N];
    typedef logic [14:0]        t_fb_tab   [65];

    // Quarter wave sin(m/N * pi/2) in Q14, Taylor series to theta^13 in Q30.
    function automatic logic signed [15:0] quarter_sine(input int unsigned m);
        logic [63:0]        theta;
        logic [63:0]        term;
        logic signed [63:0] sum;
        theta = (64'(m) * 64'd1686629713) / SINE_N;
        term  = theta;
        sum   = signed'(theta);
        for (int k = 2; k <= 12; k += 2) begin
            term = (((term * theta) >> 30) * theta) >> 30;
            term = term / 64'(k * (k + 1));
            if ((k & 2) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 16'((sum + 64'sd32768) >>> 16);
    endfunction

    function automatic t_trig_tab build_trig();
        t_trig_tab          tab;
        int unsigned        q;
        int unsigned        r;
        int unsigned        m;
        logic signed [15:0] s;
        for (int i = 0; i < SINE_N; i++) begin
            q = (4 * i) / SINE_N;
            r = 4 * i - q * SINE_N;
            m = ((q & 1) != 0) ? SINE_N - r : r;
            s = quarter_sine(m);
            tab[i] = ((q & 2) != 0) ? -s : s;
        end
        return tab;
    endfunction

    // |fb| in Q14 = isqrt(d * 2^28 * 10 / 641), at least 6554
    function automatic logic [14:0] fb_mag(input int unsigned d);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = ((64'(d) << 28) * 64'd10) / 64'd641;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_v > n) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        if (res < 64'd6554) begin
            res = 64'd6554;
        end
        return 15'(res);
    endfunction

    function automatic t_fb_tab build_fb();
        t_fb_tab tab;
        for (int i = 0; i < 65; i++) begin
            tab[i] = fb_mag(i);
        end
        return tab;
    endfunction

    localparam t_trig_tab TRIG_TAB = build_trig();
    localparam t_fb_tab   FB_TAB   = build_fb();

    function automatic logic [6:0] fb_dist(input logic [6:0] p);
        return (p >= 7'd64) ? 7'(p - 7'd64) : 7'(7'd64 - p);
    endfunction

    function automatic logic signed [15:0] fb_q14(input logic [6:0] p);
        logic signed [15:0] mag;
        mag = 16'(FB_TAB[fb_dist(p)]);
        return (p < 7'd64) ? -mag : mag;
    endfunction

    localparam logic [6:0]         FB_SET_RESET = 7'd105;
    localparam logic signed [15:0] FB_RESET     = fb_q14(FB_SET_RESET);

endpackage

/* rtl/core/cfwah_in_if.sv */
// ----------------------------------------------------------------------------
// cfwah_in_if
// Input channel: LFO update or stereo sample beat with valid/ready.
// ----------------------------------------------------------------------------
interface cfwah_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [15:0]        lfo_left;
    logic [15:0]        lfo_right;

    modport source (
        output valid, kind, sample_left, sample_right, lfo_left, lfo_right,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_left, sample_right, lfo_left, lfo_right,
        output ready
    );
endinterface

/* rtl/core/cfwah_out_if.sv */
// ----------------------------------------------------------------------------
// cfwah_out_if
// Output channel: stereo result beat with valid/ready.
// ----------------------------------------------------------------------------
interface cfwah_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] output_left;
    logic signed [15:0] output_right;

    modport source (
        output valid, output_left, output_right,
        input  ready
    );
    modport sink (
        input  valid, output_left, output_right,
        output ready
    );
endinterface

/* rtl/core/complex_feedback_wah_stereo_top.sv */
// ----------------------------------------------------------------------------
// complex_feedback_wah_stereo_top
// Stereo complex feedback delay wah on one shared multiplier and a sequencer.
//
//   port       dir   beat
//   i_in       in    kind, sample_left/right (Q1.15), lfo_left/right
//   o_out      out   output_left/right (Q1.15, saturated)
//   i_cfg_*    in    write enable, 3-bit register index, 16-bit data
//
// A sample beat runs 11 sequencer steps per channel plus 4 for the cross
// mix, then returns to idle; an LFO beat runs 6 steps per channel.
// The steps are set by the single 33x25 multiplier, one product per cycle.
// Reset is synchronous; it clears the delay line valid bits, no sweep needed.
// A finished result waits in the output register; the next beat is taken
// meanwhile and stalls only at its final step until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_feedback_wah_stereo_top
    import cfwah_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfwah_in_if.sink      i_in,
    cfwah_out_if.source   o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_DELAY);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5,
        ST_C6, ST_C7, ST_C8, ST_C9, ST_C10,
        ST_X0, ST_X1, ST_X2, ST_X3,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0]  r_depth, r_fb_set, r_len, r_phase;
    logic [15:0] r_cross, r_pan_l, r_pan_r;

    // coefficients, per channel
    logic signed [15:0] r_prev_re [2];
    logic signed [15:0] r_prev_im [2];
    logic signed [15:0] r_cur_re  [2];
    logic signed [15:0] r_cur_im  [2];
    logic [POS_W-1:0]   r_pos;

    // delay line
    logic [95:0]          r_mem [MAX_DELAY];
    logic [MAX_DELAY-1:0] r_valid;
    logic [IDX_W-1:0]     r_idx;
    logic [95:0]          r_rd;
    logic                 r_rd_ok;

    // working registers
    logic                 r_ch;
    logic signed [15:0]   r_x   [2];
    logic [15:0]          r_lfo [2];
    logic signed [57:0]   r_prod;
    logic signed [63:0]   r_acc, r_pr, r_pi;
    logic signed [15:0]   r_cr, r_ci;
    logic signed [23:0]   r_nr;
    logic [47:0]          r_wl, r_wr;
    logic signed [42:0]   r_yl, r_yr;
    logic [SINE_W-1:0]    r_sidx;

    logic                 r_out_valid;
    logic signed [15:0]   r_out_l, r_out_r;

    // combinational helpers
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [63:0] prod64;
    logic signed [15:0] fb;
    logic [14:0]        g;
    logic signed [18:0] scale;
    logic signed [16:0] diff_re, diff_im;
    logic signed [23:0] s_re, s_im;
    logic [15:0]        pan;
    logic signed [43:0] d_all;
    logic [8:0]         act_len;
    logic [8:0]         n_idx9;
    logic [SINE_W-1:0]  cos_idx;
    logic [15:0]        n_angle;
    logic signed [23:0] n_nr, n_ni;
    logic signed [63:0] n_mix_l, n_mix_r;
    logic               in_take;

    localparam logic signed [63:0] HALF_BLK = 64'(BLOCK_LEN / 2);

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -64'sd8388608) begin
            return -24'sd8388608;
        end
        return 24'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sd32767;
        end else if (v < -64'sd32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && i_rst_n;

    assign o_out.valid        = r_out_valid;
    assign o_out.output_left  = r_out_l;
    assign o_out.output_right = r_out_r;

    assign prod64  = 64'(r_prod);
    assign fb      = fb_q14(r_fb_set);
    assign g       = 15'(15'd16384 - FB_TAB[fb_dist(r_fb_set)]);
    assign scale   = 19'(fb) * 19'sd10 + 19'sd16384;
    assign diff_re = 17'(r_cur_re[r_ch]) - 17'(r_prev_re[r_ch]);
    assign diff_im = 17'(r_cur_im[r_ch]) - 17'(r_prev_im[r_ch]);
    assign pan     = r_ch ? r_pan_r : r_pan_l;
    assign d_all   = 44'(r_yr) - 44'(r_yl);
    assign cos_idx = SINE_W'(r_sidx + SINE_W'(SINE_N / 4));

    always_comb begin
        if (!r_rd_ok) begin
            s_re = '0;
            s_im = '0;
        end else if (r_ch) begin
            s_re = signed'(r_rd[47:24]);
            s_im = signed'(r_rd[23:0]);
        end else begin
            s_re = signed'(r_rd[95:72]);
            s_im = signed'(r_rd[71:48]);
        end
    end

    always_comb begin
        if (r_len == 7'd0) begin
            act_len = 9'd1;
        end else if (9'(r_len) > 9'(MAX_DELAY)) begin
            act_len = 9'(MAX_DELAY);
        end else begin
            act_len = 9'(r_len);
        end
        n_idx9 = 9'(r_idx) + 9'd1;
    end

    assign n_angle = 16'(r_prod >>> 30) + {r_phase, 9'b0} - 16'h8000;
    assign n_nr = sat24(((r_pr + 64'sd8192) >>> 14)
                      + ((prod64 + 64'sd134217728) >>> 28));
    assign n_ni = sat24((r_pi + 64'sd8192) >>> 14);
    assign n_mix_l = ((64'(r_yl) <<< 15) + r_acc + 64'sd536870912) >>> 30;
    assign n_mix_r = ((64'(r_yr) <<< 15) - r_acc + 64'sd536870912) >>> 30;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_C0: begin mul_a = 33'(diff_re); mul_b = 25'(r_pos); end
            ST_C1: begin mul_a = 33'(diff_im); mul_b = 25'(r_pos); end
            ST_C2: begin mul_a = 33'(s_re);    mul_b = 25'(r_cr);  end
            ST_C3: begin mul_a = 33'(s_im);    mul_b = 25'(r_ci);  end
            ST_C4: begin mul_a = 33'(s_im);    mul_b = 25'(r_cr);  end
            ST_C5: begin mul_a = 33'(s_re);    mul_b = 25'(r_ci);  end
            ST_C6: begin mul_a = 33'(pan);     mul_b = 25'(r_x[r_ch]); end
            ST_C7: begin mul_a = signed'(r_prod[32:0]); mul_b = 25'(g); end
            ST_C9: begin mul_a = 33'(r_nr);    mul_b = 25'(scale); end
            ST_X0: begin mul_a = 33'(d_all[21:0]); mul_b = 25'(r_cross); end
            ST_X1: begin
                mul_a = 33'(signed'(d_all[43:22]));
                mul_b = 25'(r_cross);
            end
            ST_L0: begin mul_a = 33'(r_lfo[r_ch]); mul_b = 25'(r_depth); end
            ST_L1: begin mul_a = RECIP_127; mul_b = 25'(r_prod[23:0]); end
            ST_L3: begin mul_a = 33'(TRIG_TAB[cos_idx]); mul_b = 25'(fb); end
            ST_L4: begin mul_a = 33'(TRIG_TAB[r_sidx]);  mul_b = 25'(fb); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 58'(mul_a) * 58'(mul_b);
    end

    // delay line storage: both channels share one word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_X0) begin
            r_mem[r_idx] <= {r_wl, r_wr};
        end
        if (in_take) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= 7'd60;
            r_fb_set    <= FB_SET_RESET;
            r_len       <= 7'd25;
            r_phase     <= 7'd64;
            r_cross     <= 16'd0;
            r_pan_l     <= 16'd32768;
            r_pan_r     <= 16'd32768;
            r_valid     <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_ch        <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_prev_re[c] <= FB_RESET;
                r_cur_re[c]  <= FB_RESET;
                r_prev_im[c] <= '0;
                r_cur_im[c]  <= '0;
            end
        end else begin
            if (r_out_valid && o_out.ready && r_state != ST_X3) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEPTH:    r_depth  <= i_cfg_data[6:0];
                    CFG_FEEDBACK: r_fb_set <= i_cfg_data[6:0];
                    CFG_LENGTH: begin
                        r_len   <= i_cfg_data[6:0];
                        r_valid <= '0;
                        r_idx   <= '0;
                    end
                    CFG_PHASE:    r_phase  <= i_cfg_data[6:0];
                    CFG_CROSS:    r_cross  <= i_cfg_data;
                    CFG_PAN_L:    r_pan_l  <= i_cfg_data;
                    CFG_PAN_R:    r_pan_r  <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_ch     <= 1'b0;
                        r_x[0]   <= i_in.sample_left;
                        r_x[1]   <= i_in.sample_right;
                        r_lfo[0] <= i_in.lfo_left;
                        r_lfo[1] <= i_in.lfo_right;
                        if (i_in.kind) begin
                            r_rd_ok <= r_valid[r_idx];
                            r_state <= ST_C0;
                        end else begin
                            r_prev_re <= r_cur_re;
                            r_prev_im <= r_cur_im;
                            r_state   <= ST_L0;
                        end
                    end
                end
                ST_C0: r_state <= ST_C1;
                ST_C1: begin
                    r_cr    <= 16'(64'(r_prev_re[r_ch])
                                   + ((prod64 + HALF_BLK) >>> BLK_SHIFT));
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_ci    <= 16'(64'(r_prev_im[r_ch])
                                   + ((prod64 + HALF_BLK) >>> BLK_SHIFT));
                    r_state <= ST_C3;
                end
                ST_C3: begin
                    r_acc   <= prod64;
                    r_state <= ST_C4;
                end
                ST_C4: begin
                    r_acc   <= r_acc - prod64;
                    r_state <= ST_C5;
                end
                ST_C5: begin
                    r_pr    <= r_acc;
                    r_acc   <= prod64;
                    r_state <= ST_C6;
                end
                ST_C6: begin
                    r_acc   <= r_acc + prod64;
                    r_state <= ST_C7;
                end
                ST_C7: begin
                    r_pi    <= r_acc;
                    r_state <= ST_C8;
                end
                ST_C8: begin
                    r_nr <= n_nr;
                    if (r_ch) begin
                        r_wr <= {n_nr, n_ni};
                    end else begin
                        r_wl <= {n_nr, n_ni};
                    end
                    r_state <= ST_C9;
                end
                ST_C9: r_state <= ST_C10;
                ST_C10: begin
                    if (r_ch) begin
                        r_yr    <= r_prod[42:0];
                        r_state <= ST_X0;
                    end else begin
                        r_yl    <= r_prod[42:0];
                        r_ch    <= 1'b1;
                        r_state <= ST_C0;
                    end
                end
                ST_X0: begin
                    r_valid[r_idx] <= 1'b1;
                    r_state        <= ST_X1;
                end
                ST_X1: begin
                    r_acc   <= prod64;
                    r_state <= ST_X2;
                end
                ST_X2: begin
                    r_acc   <= r_acc + (prod64 <<< 22);
                    r_state <= ST_X3;
                end
                ST_X3: begin
                    // hold until the previous result has left
                    if (!r_out_valid || o_out.ready) begin
                        r_out_l     <= sat16(n_mix_l);
                        r_out_r     <= sat16(n_mix_r);
                        r_out_valid <= 1'b1;
                        r_idx       <= (n_idx9 >= act_len) ? '0 : n_idx9[IDX_W-1:0];
                        if (r_pos < POS_W'(BLOCK_LEN)) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_L0: r_state <= ST_L1;
                ST_L1: r_state <= ST_L2;
                ST_L2: begin
                    r_sidx  <= n_angle[15 -: SINE_W];
                    r_state <= ST_L3;
                end
                ST_L3: r_state <= ST_L4;
                ST_L4: begin
                    r_cur_re[r_ch] <= 16'((prod64 + 64'sd8192) >>> 14);
                    r_state        <= ST_L5;
                end
                ST_L5: begin
                    r_cur_im[r_ch] <= 16'((prod64 + 64'sd8192) >>> 14);
                    if (r_ch) begin
                        r_pos   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= ST_L0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_AT(a_idx_in_range, i_clk, i_rst_n, 9'(r_idx) < act_len, "delay index past length")
    `ASSERT_AT(a_out_from_mix, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_X3), "result outside mix step")
    `ASSERT_NEVER(a_pos_bound, i_clk, i_rst_n, r_pos > POS_W'(BLOCK_LEN), "block position overrun")
    `ASSERT_AT(a_lfo_start, i_clk, i_rst_n, (in_take && !i_in.kind) |=> (r_state == ST_L0), "LFO beat not started")

endmodule

/* tb/cfwah_checker.sv */
// ----------------------------------------------------------------------------
// cfwah_checker
// Watches the input, output and register ports of the stereo wah, keeps its
// own fixed-point copy of the effect state and compares every output beat
// against the oldest predicted stereo pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfwah_checker
    import cfwah_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfwah_in_if         i_in,
    cfwah_out_if        i_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_err_count,
    output int          o_pending
);

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_pair;

    t_pair        wah_q[$];
    longint       sine_q14[256];

    logic [6:0]   depth_set, fb_set, len_set, phase_set;
    logic [15:0]  cross_amt;
    logic [15:0]  pan[2];
    longint       st_re[2][128];
    longint       st_im[2][128];
    longint       prev_re[2], prev_im[2], cur_re[2], cur_im[2];
    int           tap;
    int           blk_pos;

    function automatic longint rnd(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint quarter_wave(input longint unsigned m);
        longint unsigned theta, term;
        longint          acc;
        theta = (m * 64'd1686629713) / 256;
        term  = theta;
        acc   = longint'(theta);
        for (int k = 2; k <= 12; k += 2) begin
            term = (((term * theta) >> 30) * theta) >> 30;
            term = term / longint'(k * (k + 1));
            if ((k & 2) != 0) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint feedback_q14(input logic [6:0] p);
        longint unsigned n, res, b;
        longint unsigned d;
        d   = (p >= 64) ? p - 64 : 64 - p;
        n   = ((d << 28) * 10) / 641;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (res < 6554) res = 6554;
        return (p < 64) ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint sine_at(input longint unsigned ang);
        return sine_q14[(ang & 64'hFFFF) >> 8];
    endfunction

    function automatic longint blend(input longint pv, input longint cv);
        return (cv * blk_pos + pv * (128 - blk_pos) + 64) >>> 7;
    endfunction

    task automatic clear_line();
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 128; i++) begin
                st_re[c][i] = 0;
                st_im[c][i] = 0;
            end
        end
        tap = 0;
    endtask

    task automatic load_coefs(input logic [15:0] lfo_l, input logic [15:0] lfo_r);
        longint          fb;
        longint unsigned ang;
        logic [15:0]     lfo[2];
        fb = feedback_q14(fb_set);
        lfo[0] = lfo_l;
        lfo[1] = lfo_r;
        for (int c = 0; c < 2; c++) begin
            prev_re[c] = cur_re[c];
            prev_im[c] = cur_im[c];
            ang = (longint'(lfo[c]) * depth_set) / 127 + longint'(phase_set) * 512 + 32768;
            cur_re[c] = rnd(sine_at(ang + 16384) * fb, 14);
            cur_im[c] = rnd(sine_at(ang) * fb, 14);
        end
        blk_pos = 0;
    endtask

    function automatic t_pair process_sample(input logic signed [15:0] xl,
                                             input logic signed [15:0] xr);
        longint fb, g, cr, ci, pr, pi, nr, ni, c, ol, orr;
        longint chv[2];
        longint x[2];
        int     len;
        t_pair  res;
        fb   = feedback_q14(fb_set);
        g    = 16384 - ((fb < 0) ? -fb : fb);
        x[0] = xl;
        x[1] = xr;
        for (int ch = 0; ch < 2; ch++) begin
            cr = blend(prev_re[ch], cur_re[ch]);
            ci = blend(prev_im[ch], cur_im[ch]);
            pr = cr * st_re[ch][tap] - ci * st_im[ch][tap];
            pi = cr * st_im[ch][tap] + ci * st_re[ch][tap];
            nr = clip(rnd(pr, 14) + rnd(g * x[ch] * longint'(pan[ch]), 28), -8388608, 8388607);
            ni = clip(rnd(pi, 14), -8388608, 8388607);
            st_re[ch][tap] = nr;
            st_im[ch][tap] = ni;
            chv[ch] = nr * (10 * fb + 16384);
        end
        len = (len_set == 0) ? 1 : len_set;
        tap++;
        if (tap >= len) tap = 0;
        if (blk_pos < 128) blk_pos++;
        c   = cross_amt;
        ol  = clip(rnd(chv[0] * (32768 - c) + chv[1] * c, 30), -32768, 32767);
        orr = clip(rnd(chv[1] * (32768 - c) + chv[0] * c, 30), -32768, 32767);
        res.left  = 16'(ol);
        res.right = 16'(orr);
        return res;
    endfunction

    initial begin
        for (int i = 0; i < 256; i++) begin
            longint s;
            s = quarter_wave(((i % 64) == 0 && (i / 64) % 2 == 1) ? 256 :
                             (((i / 64) % 2 == 1) ? 256 - 4 * (i % 64) : 4 * (i % 64)));
            sine_q14[i] = ((i / 64) >= 2) ? -s : s;
        end
    end

    always @(posedge i_clk) begin
        t_pair got, want;
        if (!i_rst_n) begin
            depth_set   = 7'd60;
            fb_set      = 7'd105;
            len_set     = 7'd25;
            phase_set   = 7'd64;
            cross_amt   = '0;
            pan[0]      = 16'd32768;
            pan[1]      = 16'd32768;
            clear_line();
            for (int c = 0; c < 2; c++) begin
                prev_re[c] = feedback_q14(7'd105);
                cur_re[c]  = prev_re[c];
                prev_im[c] = 0;
                cur_im[c]  = 0;
            end
            blk_pos     = 0;
            wah_q.delete();
            o_err_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEPTH:    depth_set = i_cfg_data[6:0];
                    CFG_FEEDBACK: fb_set    = i_cfg_data[6:0];
                    CFG_LENGTH: begin
                        len_set = i_cfg_data[6:0];
                        clear_line();
                    end
                    CFG_PHASE:    phase_set = i_cfg_data[6:0];
                    CFG_CROSS:    cross_amt = i_cfg_data;
                    CFG_PAN_L:    pan[0]    = i_cfg_data;
                    CFG_PAN_R:    pan[1]    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind) wah_q.push_back(process_sample(i_in.sample_left,
                                                              i_in.sample_right));
                else load_coefs(i_in.lfo_left, i_in.lfo_right);
            end
            if (i_out.valid && i_out.ready) begin
                got.left  = i_out.output_left;
                got.right = i_out.output_right;
                if (wah_q.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= 10)
                        $display("%0t: unexpected output beat L=%0d R=%0d",
                                 $realtime, got.left, got.right);
                end else begin
                    want = wah_q.pop_front();
                    if (got.left !== want.left || got.right !== want.right) begin
                        o_err_count++;
                        if (o_err_count <= 10)
                            $display("%0t: mismatch L exp %0d got %0d, R exp %0d got %0d",
                                     $realtime, want.left, got.left, want.right, got.right);
                    end
                end
            end
        end
        o_pending = wah_q.size();
    end

endmodule

/* tb/complex_feedback_wah_stereo_top_tb.sv */
// ----------------------------------------------------------------------------
// complex_feedback_wah_stereo_top_tb
// Drives register settings, LFO update beats and stereo sample beats into the
// wah with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_feedback_wah_stereo_top_tb;
    import cfwah_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic       KIND_LFO   = 1'b0;
    localparam logic       KIND_AUDIO = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    int          err_count;
    int          pending;
    bit          long_hold = 1'b0;

    cfwah_in_if  in_ch();
    cfwah_out_if out_ch();

    complex_feedback_wah_stereo_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cfwah_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.kind         = 1'b0;
        in_ch.sample_left  = '0;
        in_ch.sample_right = '0;
        in_ch.lfo_left     = '0;
        in_ch.lfo_right    = '0;
        out_ch.ready       = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: bursts of steady ready, random stalls, and the long hold.
    initial begin
        int n;
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (800) @(posedge i_clk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(20, 120);
                repeat (n) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic kind, input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d, input bit no_gap);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.sample_left  <= a;
        in_ch.sample_right <= b;
        in_ch.lfo_left     <= c;
        in_ch.lfo_right    <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [15:0] l, input logic [15:0] r, input bit no_gap);
        send_beat(KIND_AUDIO, l, r, 16'($urandom), 16'($urandom), no_gap);
    endtask

    task automatic send_lfo(input logic [15:0] l, input logic [15:0] r, input bit no_gap);
        send_beat(KIND_LFO, 16'($urandom), 16'($urandom), l, r, no_gap);
    endtask

    // Drain results, then let an LFO beat still in flight finish.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [6:0] dep, input logic [6:0] fb, input logic [6:0] len,
                             input logic [6:0] ph, input logic [15:0] cr,
                             input logic [15:0] pl, input logic [15:0] pr);
        write_reg(CFG_DEPTH, 16'(dep));
        write_reg(CFG_FEEDBACK, 16'(fb));
        write_reg(CFG_LENGTH, 16'(len));
        write_reg(CFG_PHASE, 16'(ph));
        write_reg(CFG_CROSS, cr);
        write_reg(CFG_PAN_L, pl);
        write_reg(CFG_PAN_R, pr);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly an LFO beat followed by a run of samples; sometimes a run past
    // the block length, sometimes bare samples.
    task automatic random_traffic(input int n_items, input bit no_gap);
        int sent, run;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) != 0) begin
                send_lfo(16'($urandom), 16'($urandom), no_gap);
                sent++;
            end
            run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(120, 160);
            for (int i = 0; i < run && sent < n_items; i++) begin
                send_sample(pick_word(), pick_word(), no_gap);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients first, then extremes of samples and LFO values.
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'h0000, 16'hFFFF, 1'b0);
        send_lfo(16'h0000, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_lfo(16'hFFFF, 16'h0000, 1'b0);
        for (int i = 0; i < 8; i++) send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_lfo(16'h8000, 16'h4000, 1'b0);
        for (int i = 0; i < 6; i++) send_sample(16'h5555, 16'hAAAA, 1'b0);
        random_traffic(200, 1'b0);
        drain();

        write_all(7'd127, 7'd127, 7'd100, 7'd127, 16'd32768, 16'd0, 16'hFFFF);
        random_traffic(220, 1'b0);
        drain();

        // Zero length acts as one; full cross mix and beyond.
        write_all(7'd0, 7'd0, 7'd0, 7'd0, 16'hFFFF, 16'd32768, 16'd32768);
        random_traffic(220, 1'b0);
        drain();

        write_all(7'd90, 7'd64, 7'd1, 7'd30, 16'd8000, 16'd20000, 16'd30000);
        random_traffic(120, 1'b0);
        // Pause until every result is back, then carry on.
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_traffic(100, 1'b0);
        drain();

        write_all(7'd127, 7'd20, 7'd127, 7'd100, 16'd0, 16'd32768, 16'd32768);
        write_reg(CFG_UNUSED, 16'hFFFF);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        random_traffic(220, 1'b0);
        drain();

        write_all(7'($urandom), 7'($urandom), 7'($urandom_range(1, 100)), 7'($urandom),
                  16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                  16'($urandom_range(0, 32768)));
        random_traffic(220, 1'b0);
        drain();

        // Back to defaults; hold the output off while beats keep coming.
        write_all(7'd60, 7'd105, 7'd25, 7'd64, 16'd0, 16'd32768, 16'd32768);
        long_hold = 1'b1;
        random_traffic(80, 1'b1);
        random_traffic(300, 1'b0);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
